// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the heading unit.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled at the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/hdg_pkg.sv
// Types and constants of the magnetometer heading unit.
// Used by every module of the unit; depends on nothing.
package hdg_pkg;

   localparam int DIFF_W    = 17;
   localparam int DATA_W    = 28;
   localparam int ANGLE_W   = 25;
   localparam int FRAC_BITS = 8;
   localparam int TABLE_LEN = 24;
   localparam int SAMPLE_W  = 16;
   localparam int OFFSET_W  = 12;
   localparam int HEADING_W = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_X_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_OFFSET = 2'd1;

   localparam logic signed [ANGLE_W-1:0] HALF_TURN = 25'sd4608000;
   localparam logic [ANGLE_W:0]          FULL_TURN = 26'd9216000;
   localparam logic [ANGLE_W:0]          ROUND_HALF = 26'd128;
   localparam logic [HEADING_W-1:0]      HEADING_MOD = 16'd36000;

   localparam logic [ANGLE_W-2:0] ATAN_TABLE [TABLE_LEN] = '{
      24'd1152000, 24'd680065, 24'd359328, 24'd182400,
      24'd91554,   24'd45822,  24'd22916,  24'd11459,
      24'd5730,    24'd2865,   24'd1432,   24'd716,
      24'd358,     24'd179,    24'd90,     24'd45,
      24'd22,      24'd11,     24'd6,      24'd3,
      24'd1,       24'd1,      24'd0,      24'd0
   };

   typedef struct packed {
      logic                      valid;
      logic                      zero;
      logic signed [DATA_W-1:0]  x;
      logic signed [DATA_W-1:0]  y;
      logic signed [ANGLE_W-1:0] z;
   } hdg_vec_type;

endpackage

// File: rtl/core/magnetometer_heading_unit.sv
// Magnetometer heading unit: hard-iron offset removal and atan2 heading by pipelined CORDIC.
// A request passes the front registers, the ANGLE_STEPS step registers and the back registers to its result.
// Throughput is one request per cycle while no result waits stalled; every register stage holds while the result waits.
// Synchronous reset empties the pipeline and clears both offsets to zero.
// Depends on hdg_pkg, hdg_front, hdg_step and hdg_back.
module magnetometer_heading_unit
   import hdg_pkg::*;
#(
   parameter int ANGLE_STEPS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_x_sample,
   input  logic [SAMPLE_W-1:0]   req_y_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [HEADING_W-1:0]  rsp_heading_centideg,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [OFFSET_W-1:0]   csr_wdata
);

   logic signed [OFFSET_W-1:0] x_offset_ff, y_offset_ff;
   logic                       en;
   hdg_vec_type                chain [ANGLE_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         x_offset_ff <= '0;
         y_offset_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_X_OFFSET: x_offset_ff <= $signed(csr_wdata);
            CSR_Y_OFFSET: y_offset_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   hdg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .x_sample ($signed(req_x_sample)),
      .y_sample ($signed(req_y_sample)),
      .x_offset (x_offset_ff),
      .y_offset (y_offset_ff),
      .vec_out  (chain[0])
   );

   for (genvar k = 0; k < ANGLE_STEPS; k++) begin : g_step
      hdg_step #(.STEP(k)) u_step (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .vec_in  (chain[k]),
         .vec_out (chain[k+1])
      );
   end

   hdg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .vec_in    (chain[ANGLE_STEPS]),
      .out_valid (rsp_valid),
      .heading   (rsp_heading_centideg)
   );

endmodule

// File: rtl/core/hdg_front.sv
// Front end of the heading unit: offset subtraction and half-plane pre-rotation.
// Depends on hdg_pkg.
module hdg_front
   import hdg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic signed [SAMPLE_W-1:0] x_sample,
   input  logic signed [SAMPLE_W-1:0] y_sample,
   input  logic signed [OFFSET_W-1:0] x_offset,
   input  logic signed [OFFSET_W-1:0] y_offset,
   output hdg_vec_type                vec_out
);

   logic                      a_valid_ff;
   logic signed [DIFF_W-1:0]  dx_ff, dy_ff;
   logic signed [DIFF_W-1:0]  dx_in, dy_in;

   logic                      b_valid_ff;
   logic                      zero_ff, zero_in;
   logic signed [DATA_W-1:0]  x_ff, y_ff, x_in, y_in;
   logic signed [ANGLE_W-1:0] z_ff, z_in;
   logic signed [DATA_W-1:0]  dx_ext, dy_ext;

   assign dx_in = DIFF_W'(x_sample) - DIFF_W'(x_offset);
   assign dy_in = DIFF_W'(y_sample) - DIFF_W'(y_offset);

   assign dx_ext = DATA_W'(dx_ff);
   assign dy_ext = DATA_W'(dy_ff);

   always_comb begin
      zero_in = (dx_ff == '0) && (dy_ff == '0);
      if (dx_ff[DIFF_W-1]) begin
         x_in = (-dx_ext) <<< FRAC_BITS;
         y_in = (-dy_ext) <<< FRAC_BITS;
         z_in = HALF_TURN;
      end else begin
         x_in = dx_ext <<< FRAC_BITS;
         y_in = dy_ext <<< FRAC_BITS;
         z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         zero_ff <= zero_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
      end
   end

   assign vec_out = '{valid: b_valid_ff, zero: zero_ff, x: x_ff, y: y_ff, z: z_ff};

endmodule

// File: rtl/core/hdg_step.sv
// One registered micro-rotation of the vectoring CORDIC.
// Depends on hdg_pkg for the vector type and the arctangent table.
module hdg_step
   import hdg_pkg::*;
#(
   parameter int STEP = 0
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  hdg_vec_type vec_in,
   output hdg_vec_type vec_out
);

   localparam logic signed [ANGLE_W-1:0] ANGLE = $signed({1'b0, ATAN_TABLE[STEP]});

   logic                      valid_ff;
   logic                      zero_ff;
   logic signed [DATA_W-1:0]  x_ff, y_ff, x_in, y_in;
   logic signed [ANGLE_W-1:0] z_ff, z_in;
   logic signed [DATA_W-1:0]  x_sh, y_sh;

   assign x_sh = vec_in.x >>> STEP;
   assign y_sh = vec_in.y >>> STEP;

   always_comb begin
      if (!vec_in.y[DATA_W-1]) begin
         x_in = vec_in.x + y_sh;
         y_in = vec_in.y - x_sh;
         z_in = vec_in.z + ANGLE;
      end else begin
         x_in = vec_in.x - y_sh;
         y_in = vec_in.y + x_sh;
         z_in = vec_in.z - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= vec_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff <= vec_in.zero;
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
      end
   end

   assign vec_out = '{valid: valid_ff, zero: zero_ff, x: x_ff, y: y_ff, z: z_ff};

endmodule

// File: rtl/core/hdg_back.sv
// Back end of the heading unit: turn wrap, rounding to hundredths and the result register.
// Depends on hdg_pkg.
module hdg_back
   import hdg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  hdg_vec_type          vec_in,
   output logic                 out_valid,
   output logic [HEADING_W-1:0] heading
);

   logic                 f_valid_ff;
   logic                 f_zero_ff;
   logic [HEADING_W-1:0] coarse_ff, coarse_in;
   logic signed [ANGLE_W:0] z_ext;
   logic [ANGLE_W:0]     wrapped;

   logic                 out_valid_ff;
   logic [HEADING_W-1:0] heading_ff, heading_in;

   assign z_ext   = (ANGLE_W + 1)'(vec_in.z);
   assign wrapped = $unsigned(z_ext) + (vec_in.z[ANGLE_W-1] ? FULL_TURN : '0) + ROUND_HALF;
   assign coarse_in = wrapped[FRAC_BITS +: HEADING_W];

   always_comb begin
      if (f_zero_ff) begin
         heading_in = '0;
      end else if (coarse_ff >= HEADING_MOD) begin
         heading_in = coarse_ff - HEADING_MOD;
      end else begin
         heading_in = coarse_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff   <= vec_in.valid;
         out_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_zero_ff  <= vec_in.zero;
         coarse_ff  <= coarse_in;
         heading_ff <= heading_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign heading   = heading_ff;

endmodule

// File: rtl/core/hdg_checker.sv
// Port-level checker for the magnetometer heading unit, bound to the top level.
// Depends on hdg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hdg_checker
   import hdg_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [HEADING_W-1:0] rsp_heading_centideg
);

   `ASSERT_IMPLIES(a_heading_range, clock, reset, rsp_valid, rsp_heading_centideg < HEADING_MOD, "heading out of range")
   `ASSERT_IMPLIES(a_stall_cause, clock, 1'b0, req_stall, rsp_valid && rsp_stall, "request stalled without a blocked result")
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result valid after reset")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_heading_centideg), "stalled result changed")

endmodule

bind magnetometer_heading_unit hdg_checker u_hdg_checker (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_heading_centideg (rsp_heading_centideg)
);
